// File: rtl/core/cbad_pkg.sv
// Shared types, opcode codes and probability tables for the CABAC arithmetic decoder.
// Used by cbad_front, cbad_back and the top level; depends on nothing else.
package cbad_pkg;

  // Opcodes as they arrive on the request channel.
  localparam logic [2:0] OP_FEED      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_DECISION  = 3'd2;
  localparam logic [2:0] OP_BYPASS    = 3'd3;
  localparam logic [2:0] OP_TERMINATE = 3'd4;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Range the engine starts from after a start request.
  localparam logic [8:0] RANGE_START = 9'd510;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_FEED,
    KIND_START,
    KIND_DECISION,
    KIND_BYPASS,
    KIND_TERMINATE
  } cbad_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_STARVED = 2'd1,
    STATUS_FULL    = 2'd2
  } cbad_status_e;

  typedef struct packed {
    cbad_kind_e  kind;
    logic [7:0]  stream_byte;
    logic [5:0]  ctx_state;
    logic        ctx_mps;
  } cbad_item_t;

  typedef struct packed {
    logic       valid;
    cbad_item_t item;
  } cbad_head_t;

  // LPS sub-range, indexed by probability state and range quarter.
  localparam logic [7:0] LPS_RANGE [64][4] = '{
    '{8'd128, 8'd176, 8'd208, 8'd240}, '{8'd128, 8'd167, 8'd197, 8'd227},
    '{8'd128, 8'd158, 8'd187, 8'd216}, '{8'd123, 8'd150, 8'd178, 8'd205},
    '{8'd116, 8'd142, 8'd169, 8'd195}, '{8'd111, 8'd135, 8'd160, 8'd185},
    '{8'd105, 8'd128, 8'd152, 8'd175}, '{8'd100, 8'd122, 8'd144, 8'd166},
    '{8'd95,  8'd116, 8'd137, 8'd158}, '{8'd90,  8'd110, 8'd130, 8'd150},
    '{8'd85,  8'd104, 8'd123, 8'd142}, '{8'd81,  8'd99,  8'd117, 8'd135},
    '{8'd77,  8'd94,  8'd111, 8'd128}, '{8'd73,  8'd89,  8'd105, 8'd122},
    '{8'd69,  8'd85,  8'd100, 8'd116}, '{8'd66,  8'd80,  8'd95,  8'd110},
    '{8'd62,  8'd76,  8'd90,  8'd104}, '{8'd59,  8'd72,  8'd86,  8'd99},
    '{8'd56,  8'd69,  8'd81,  8'd94},  '{8'd53,  8'd65,  8'd77,  8'd89},
    '{8'd51,  8'd62,  8'd73,  8'd85},  '{8'd48,  8'd59,  8'd69,  8'd80},
    '{8'd46,  8'd56,  8'd66,  8'd76},  '{8'd43,  8'd53,  8'd63,  8'd72},
    '{8'd41,  8'd50,  8'd59,  8'd69},  '{8'd39,  8'd48,  8'd56,  8'd65},
    '{8'd37,  8'd45,  8'd54,  8'd62},  '{8'd35,  8'd43,  8'd51,  8'd59},
    '{8'd33,  8'd41,  8'd48,  8'd56},  '{8'd32,  8'd39,  8'd46,  8'd53},
    '{8'd30,  8'd37,  8'd43,  8'd50},  '{8'd29,  8'd35,  8'd41,  8'd48},
    '{8'd27,  8'd33,  8'd39,  8'd45},  '{8'd26,  8'd31,  8'd37,  8'd43},
    '{8'd24,  8'd30,  8'd35,  8'd41},  '{8'd23,  8'd28,  8'd33,  8'd39},
    '{8'd22,  8'd27,  8'd32,  8'd37},  '{8'd21,  8'd26,  8'd30,  8'd35},
    '{8'd20,  8'd24,  8'd29,  8'd33},  '{8'd19,  8'd23,  8'd27,  8'd31},
    '{8'd18,  8'd22,  8'd26,  8'd30},  '{8'd17,  8'd21,  8'd25,  8'd28},
    '{8'd16,  8'd20,  8'd23,  8'd27},  '{8'd15,  8'd19,  8'd22,  8'd25},
    '{8'd14,  8'd18,  8'd21,  8'd24},  '{8'd14,  8'd17,  8'd20,  8'd23},
    '{8'd13,  8'd16,  8'd19,  8'd22},  '{8'd12,  8'd15,  8'd18,  8'd21},
    '{8'd12,  8'd14,  8'd17,  8'd20},  '{8'd11,  8'd14,  8'd16,  8'd19},
    '{8'd11,  8'd13,  8'd15,  8'd18},  '{8'd10,  8'd12,  8'd15,  8'd17},
    '{8'd10,  8'd12,  8'd14,  8'd16},  '{8'd9,   8'd11,  8'd13,  8'd15},
    '{8'd9,   8'd11,  8'd12,  8'd14},  '{8'd8,   8'd10,  8'd12,  8'd14},
    '{8'd8,   8'd9,   8'd11,  8'd13},  '{8'd7,   8'd9,   8'd11,  8'd12},
    '{8'd7,   8'd9,   8'd10,  8'd12},  '{8'd7,   8'd8,   8'd10,  8'd11},
    '{8'd6,   8'd8,   8'd9,   8'd11},  '{8'd6,   8'd7,   8'd9,   8'd10},
    '{8'd6,   8'd7,   8'd8,   8'd9},   '{8'd2,   8'd2,   8'd2,   8'd2}
  };

  // Probability state after an LPS.
  localparam logic [5:0] LPS_NEXT [64] = '{
    6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,  6'd6,  6'd7,
    6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12, 6'd13, 6'd13, 6'd15, 6'd15,
    6'd16, 6'd16, 6'd18, 6'd18, 6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22,
    6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
    6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33,
    6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36, 6'd36, 6'd36, 6'd37, 6'd37,
    6'd37, 6'd38, 6'd38, 6'd63
  };

  // Leading zeros of a 9-bit range, nine for zero: the renormalization shift.
  function automatic logic [3:0] lzc9(input logic [8:0] value);
    logic [3:0] count;
    logic       found;
    count = 4'd9;
    found = 1'b0;
    for (int i = 8; i >= 0; i--) begin
      if (!found && value[i]) begin
        count = 4'(8 - i);
        found = 1'b1;
      end
    end
    return count;
  endfunction

endpackage

// File: rtl/core/cabac_binary_arithmetic_decoder.sv
// Top level of the CABAC arithmetic decoder: request queue front end and engine back end.
// Depends on cbad_pkg, cbad_front and cbad_back.
//
// This block is the H.264 CABAC arithmetic decoding engine with a small MSB-first bit
// buffer in front of it. Each request carries one opcode: feed a byte into the buffer,
// start (range 510, offset from the next nine buffered bits), decode a context-coded
// decision, a bypass bin or a terminate bin; unused opcodes do nothing and report ok.
// Every request produces exactly one result with the bin, the updated context (echoed
// for anything but a decision) and a status: ok, starved (too few buffered bits, nothing
// changed) or feed dropped because the buffer is full. The front end accepts requests
// into a two-entry queue; the back end takes one request per cycle from the queue
// while its result register is free or being emptied, updates range, offset, buffer
// and context combinationally and registers the result. The block sustains one
// request per cycle while results are taken, set by the loop through the range and
// offset registers and the bit buffer. While a result waits to be taken the engine
// holds, and the queue still accepts up to two requests. There is no clearing pass
// after reset; the engine starts at range 510 with an empty buffer.
module cabac_binary_arithmetic_decoder import cbad_pkg::*; #(
  parameter int unsigned BUFFER_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] stream_byte_i,
  input  logic [5:0] ctx_state_i,
  input  logic       ctx_mps_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       bin_value_o,
  output logic [5:0] next_ctx_state_o,
  output logic       next_ctx_mps_o,
  output logic [1:0] status_o
);

  // Head of the request queue as seen by the engine, and the engine's pop.
  cbad_head_t head;
  logic       pop;

  cbad_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .stream_byte_i(stream_byte_i),
    .ctx_state_i  (ctx_state_i),
    .ctx_mps_i    (ctx_mps_i),
    .pop_i        (pop),
    .head_o       (head)
  );

  // The engine pops a request whenever its result register is free or being emptied.
  cbad_back #(
    .BUFFER_BITS(BUFFER_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_value_o     (bin_value_o),
    .next_ctx_state_o(next_ctx_state_o),
    .next_ctx_mps_o  (next_ctx_mps_o),
    .status_o        (status_o)
  );

endmodule

// File: rtl/core/cbad_front.sv
// Front end of the CABAC arithmetic decoder: accepts requests, classifies the opcode
// and holds them in a short queue for the back end. Depends on cbad_pkg.
module cbad_front import cbad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] stream_byte_i,
  input  logic [5:0] ctx_state_i,
  input  logic       ctx_mps_i,
  input  logic       pop_i,
  output cbad_head_t head_o
);

  cbad_item_t             queue_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  cbad_kind_e             kind;
  logic                   push;

  // Unused opcodes become no-operations here so the back end never sees them.
  always_comb begin
    unique case (opcode_i)
      OP_FEED:      kind = KIND_FEED;
      OP_START:     kind = KIND_START;
      OP_DECISION:  kind = KIND_DECISION;
      OP_BYPASS:    kind = KIND_BYPASS;
      OP_TERMINATE: kind = KIND_TERMINATE;
      default:      kind = KIND_NOP;
    endcase
  end

  assign in_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{kind: kind, stream_byte: stream_byte_i,
                             ctx_state: ctx_state_i, ctx_mps: ctx_mps_i};
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("request queue count beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("request popped from an empty queue");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_o.valid && !pop_i |=> head_o.valid && $stable(head_o.item))
    else $error("waiting request changed before it was taken");

endmodule

// File: rtl/core/cbad_back.sv
// Back end of the CABAC arithmetic decoder: bit buffer, range and offset update,
// context update and the result register. Depends on cbad_pkg.
module cbad_back import cbad_pkg::*; #(
  parameter int unsigned BUFFER_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cbad_head_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       bin_value_o,
  output logic [5:0] next_ctx_state_o,
  output logic       next_ctx_mps_o,
  output logic [1:0] status_o
);

  localparam int unsigned HELD_W = $clog2(BUFFER_BITS + 1);

  logic [8:0]             range_q, range_d;
  logic [8:0]             offset_q, offset_d;
  logic [BUFFER_BITS-1:0] store_q, store_d;
  logic [HELD_W-1:0]      held_q, held_d;

  logic                   out_valid_q;
  logic                   bin_q, bin_d;
  logic [5:0]             nst_q, nst_d;
  logic                   nmps_q, nmps_d;
  cbad_status_e           status_q, status_d;

  logic                   load;
  cbad_item_t             item;
  logic [BUFFER_BITS+8:0] window;
  logic [8:0]             peek9;
  logic [8:0]             rl, rm, nr, term_r, renorm_base_r, renorm_base_o;
  logic                   lps;
  logic [3:0]             shift_n;
  logic [17:0]            off_shift;
  logic [9:0]             byp_v, byp_sub;
  logic                   byp_ge;

  assign item  = head_i.item;
  assign load  = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = load;

  // Next nine buffered bits, oldest first, zero padded when fewer are held.
  assign window = {store_q, 9'b0} >> held_q;
  assign peek9  = window[8:0];

  assign rl = {1'b0, LPS_RANGE[item.ctx_state][range_q[7:6]]};
  assign rm = range_q - rl;
  assign lps = (offset_q >= rm);
  assign nr  = lps ? rl : rm;
  assign term_r = range_q - 9'd2;

  assign byp_v   = {offset_q, peek9[8]};
  assign byp_ge  = (byp_v >= {1'b0, range_q});
  assign byp_sub = byp_v - {1'b0, range_q};

  // Shift count, and range and offset before renormalization.
  always_comb begin
    if (item.kind == KIND_DECISION) begin
      shift_n       = lzc9(nr);
      renorm_base_r = nr;
      renorm_base_o = lps ? (offset_q - rm) : offset_q;
    end else begin
      shift_n       = lzc9(term_r);
      renorm_base_r = term_r;
      renorm_base_o = offset_q;
    end
  end

  assign off_shift = {renorm_base_o, peek9} << shift_n;

  always_comb begin
    range_d  = range_q;
    offset_d = offset_q;
    store_d  = store_q;
    held_d   = held_q;
    bin_d    = 1'b0;
    nst_d    = item.ctx_state;
    nmps_d   = item.ctx_mps;
    status_d = STATUS_OK;
    unique case (item.kind)
      KIND_FEED: begin
        if (held_q > HELD_W'(BUFFER_BITS - 8)) begin
          status_d = STATUS_FULL;
        end else begin
          store_d = {store_q[BUFFER_BITS-9:0], item.stream_byte};
          held_d  = held_q + HELD_W'(8);
        end
      end
      KIND_START: begin
        if (held_q < HELD_W'(9)) begin
          status_d = STATUS_STARVED;
        end else begin
          offset_d = peek9;
          range_d  = RANGE_START;
          held_d   = held_q - HELD_W'(9);
        end
      end
      KIND_DECISION: begin
        if (held_q < HELD_W'(shift_n)) begin
          status_d = STATUS_STARVED;
        end else begin
          range_d  = 9'(renorm_base_r << shift_n);
          offset_d = off_shift[17:9];
          held_d   = held_q - HELD_W'(shift_n);
          if (lps) begin
            bin_d  = ~item.ctx_mps;
            nst_d  = LPS_NEXT[item.ctx_state];
            nmps_d = (item.ctx_state == 6'd0) ? ~item.ctx_mps : item.ctx_mps;
          end else begin
            bin_d  = item.ctx_mps;
            nst_d  = (item.ctx_state < 6'd62) ? item.ctx_state + 6'd1 : item.ctx_state;
          end
        end
      end
      KIND_BYPASS: begin
        if (held_q == '0) begin
          status_d = STATUS_STARVED;
        end else begin
          bin_d    = byp_ge;
          offset_d = byp_ge ? byp_sub[8:0] : byp_v[8:0];
          held_d   = held_q - HELD_W'(1);
        end
      end
      KIND_TERMINATE: begin
        if (offset_q >= term_r) begin
          // End of slice: no renormalization, no bits used.
          bin_d   = 1'b1;
          range_d = term_r;
        end else if (held_q < HELD_W'(shift_n)) begin
          status_d = STATUS_STARVED;
        end else begin
          range_d  = 9'(renorm_base_r << shift_n);
          offset_d = off_shift[17:9];
          held_d   = held_q - HELD_W'(shift_n);
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q     <= RANGE_START;
      offset_q    <= '0;
      store_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        range_q  <= range_d;
        offset_q <= offset_d;
        store_q  <= store_d;
        held_q   <= held_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bin_q    <= bin_d;
      nst_q    <= nst_d;
      nmps_q   <= nmps_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bin_value_o      = bin_q;
  assign next_ctx_state_o = nst_q;
  assign next_ctx_mps_o   = nmps_q;
  assign status_o         = status_q;

  a_held_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HELD_W'(BUFFER_BITS))
    else $error("bit buffer count beyond its capacity");

  a_starved_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && status_d == STATUS_STARVED |=>
      $stable(range_q) && $stable(offset_q) && $stable(held_q))
    else $error("starved request changed the engine state");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && status_d == STATUS_FULL |=> $stable(held_q) && $stable(store_q))
    else $error("dropped feed changed the bit buffer");

endmodule
